>>> rtl/shortest_float_encoder_unit_assert.svh
// Assertion macros for the shortest float encoder.
// Used by rtl/shortest_float_encoder_unit.sv; needs no other file.
`ifndef SHORTEST_FLOAT_ENCODER_UNIT_ASSERT_SVH
`define SHORTEST_FLOAT_ENCODER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define SFE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> rtl/sfe_pkg.sv
// Package for the shortest float encoder: head codes and field constants.
// Used by rtl/shortest_float_encoder_unit.sv; depends on nothing.
package sfe_pkg;

    localparam logic [7:0] HEAD_HALF   = 8'hF9;
    localparam logic [7:0] HEAD_SINGLE = 8'hFA;
    localparam logic [7:0] HEAD_DOUBLE = 8'hFB;

    localparam logic [3:0] BYTES_HALF   = 4'd2;
    localparam logic [3:0] BYTES_SINGLE = 4'd4;
    localparam logic [3:0] BYTES_DOUBLE = 4'd8;

    localparam logic [10:0] EXP_ALL_ONE = 11'h7FF;

    // Biased double exponent limits for normal halves and singles.
    localparam logic [10:0] HALF_EXP_MIN   = 11'd1009;  // 1023 - 14
    localparam logic [10:0] HALF_EXP_MAX   = 11'd1038;  // 1023 + 15
    localparam logic [10:0] SINGLE_EXP_MIN = 11'd897;   // 1023 - 126
    localparam logic [10:0] SINGLE_EXP_MAX = 11'd1150;  // 1023 + 127

    // Rebias offsets: double biased exponent minus this gives the target.
    localparam logic [10:0] HALF_REBIAS   = 11'd1008;   // 1023 - 15
    localparam logic [10:0] SINGLE_REBIAS = 11'd896;    // 1023 - 127

    localparam logic [15:0] HALF_QNAN    = 16'h7E00;
    localparam logic [15:0] HALF_POS_INF = 16'h7C00;
    localparam logic [15:0] HALF_NEG_INF = 16'hFC00;

    typedef struct packed {
        logic [7:0]  head_byte;
        logic [63:0] payload;
        logic [3:0]  payload_bytes;
    } sfe_result_t;

endpackage

>>> rtl/shortest_float_encoder_unit.sv
// Shortest float encoder: one registered stage that turns a double into its
// shortest CBOR float head byte and payload. Depends on rtl/sfe_pkg.sv and
// rtl/shortest_float_encoder_unit_assert.svh.
//
// Each request carries one IEEE binary64 pattern and yields exactly one
// result in the next cycle: head 0xF9/0xFA/0xFB with a right-aligned payload
// of 2, 4 or 8 bytes. Zeros and denormals give a signed half zero, NaNs give
// 0x7E00, infinities 0x7C00/0xFC00. The block takes one request per clock
// while the single result register is empty or being drained; a stalled
// result holds the input off.
`include "shortest_float_encoder_unit_assert.svh"

module shortest_float_encoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_head_byte,
    output logic [63:0] m_payload,
    output logic [3:0]  m_payload_bytes
);

    logic                 valid_reg;
    sfe_pkg::sfe_result_t result_reg;
    sfe_pkg::sfe_result_t result_next;

    logic        sign;
    logic [10:0] efield;
    logic [51:0] mant;
    logic        is_half;
    logic        is_single;
    logic [10:0] half_exp;
    logic [10:0] single_exp;

    assign sign   = s_value_bits[63];
    assign efield = s_value_bits[62:52];
    assign mant   = s_value_bits[51:0];

    // Range tests on the biased exponent and the discarded mantissa bits.
    assign is_half   = (efield >= sfe_pkg::HALF_EXP_MIN) && (efield <= sfe_pkg::HALF_EXP_MAX)
                       && (mant[41:0] == 42'd0);
    assign is_single = (efield >= sfe_pkg::SINGLE_EXP_MIN)
                       && (efield <= sfe_pkg::SINGLE_EXP_MAX) && (mant[28:0] == 29'd0);
    assign half_exp   = efield - sfe_pkg::HALF_REBIAS;
    assign single_exp = efield - sfe_pkg::SINGLE_REBIAS;

    // Pick the shortest encoding in priority order.
    always_comb begin
        result_next.head_byte     = sfe_pkg::HEAD_DOUBLE;
        result_next.payload       = s_value_bits;
        result_next.payload_bytes = sfe_pkg::BYTES_DOUBLE;
        if (efield == 11'd0) begin
            result_next.head_byte     = sfe_pkg::HEAD_HALF;
            result_next.payload       = {48'd0, sign, 15'd0};
            result_next.payload_bytes = sfe_pkg::BYTES_HALF;
        end else if (is_half) begin
            result_next.head_byte     = sfe_pkg::HEAD_HALF;
            result_next.payload       = {48'd0, sign, half_exp[4:0], mant[51:42]};
            result_next.payload_bytes = sfe_pkg::BYTES_HALF;
        end else if (is_single) begin
            result_next.head_byte     = sfe_pkg::HEAD_SINGLE;
            result_next.payload       = {32'd0, sign, single_exp[7:0], mant[51:29]};
            result_next.payload_bytes = sfe_pkg::BYTES_SINGLE;
        end else if (efield == sfe_pkg::EXP_ALL_ONE) begin
            result_next.head_byte     = sfe_pkg::HEAD_HALF;
            result_next.payload_bytes = sfe_pkg::BYTES_HALF;
            if (mant != 52'd0) begin
                result_next.payload = {48'd0, sfe_pkg::HALF_QNAN};
            end else if (sign) begin
                result_next.payload = {48'd0, sfe_pkg::HALF_NEG_INF};
            end else begin
                result_next.payload = {48'd0, sfe_pkg::HALF_POS_INF};
            end
        end
    end

    // Accept a new request whenever the result register is free or draining.
    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_head_byte     = result_reg.head_byte;
    assign m_payload       = result_reg.payload;
    assign m_payload_bytes = result_reg.payload_bytes;

    // A stalled result must not be overwritten or dropped.
    `SFE_ASSERT(a_hold_on_stall,
        (m_valid && !m_ready) |=> (m_valid && $stable(result_reg)),
        "result changed while stalled")
    // Head byte and byte count always agree.
    `SFE_ASSERT(a_head_len,
        m_valid |-> ((m_head_byte == sfe_pkg::HEAD_HALF
                      && m_payload_bytes == sfe_pkg::BYTES_HALF)
                     || (m_head_byte == sfe_pkg::HEAD_SINGLE
                         && m_payload_bytes == sfe_pkg::BYTES_SINGLE)
                     || (m_head_byte == sfe_pkg::HEAD_DOUBLE
                         && m_payload_bytes == sfe_pkg::BYTES_DOUBLE)),
        "head and length disagree")
    // Bits above a short payload are zero.
    `SFE_ASSERT(a_upper_zero,
        (m_valid && m_head_byte != sfe_pkg::HEAD_DOUBLE) |-> (m_payload[63:32] == 32'd0),
        "short payload has upper bits")
    // An accepted request appears at the output in the next cycle.
    `SFE_ASSERT(a_latency, (s_valid && s_ready) |=> m_valid, "accepted request not presented")
    // Reset leaves no result pending.
    `SFE_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule
